FILE: src/itr_pkg.sv
package itr_pkg;

  localparam int CHARS_PER_RESULT = 8;

  localparam int VAL_W  = 64;
  localparam int IN_W   = 72;   // cmd(3), value(64), is_signed(1), is_wide(1), pad
  localparam int OUT_W  = 72;   // text_chars(64), char_count(4), pad
  localparam int CNT_W  = 4;
  localparam int IDX_W  = (CHARS_PER_RESULT > 1) ? $clog2(CHARS_PER_RESULT) : 1;

  localparam int BCD_DIGITS = 20;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int DIG_W      = 80;
  localparam int DCNT_W     = 7;

  localparam logic [2:0] CMD_BIN  = 3'd0;
  localparam logic [2:0] CMD_DEC  = 3'd1;
  localparam logic [2:0] CMD_HEX  = 3'd2;
  localparam logic [2:0] CMD_PTR  = 3'd3;
  localparam logic [2:0] CMD_BOOL = 3'd4;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam logic [7:0] DIGIT_SET [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_DLOAD,
    ST_SKIP,
    ST_SIGN,
    ST_PFX0,
    ST_PFX1,
    ST_DIGS,
    ST_BOOL
  } state_e;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] ch;
  } char_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return DIGIT_SET[d];
  endfunction

  // "true" or "false", one letter per index
  function automatic logic [7:0] bool_char(input logic bit_v, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    if (bit_v) begin
      case (idx)
        3'd0:    c = 8'h74;
        3'd1:    c = 8'h72;
        3'd2:    c = 8'h75;
        3'd3:    c = 8'h65;
        default: c = 8'h00;
      endcase
    end else begin
      case (idx)
        3'd0:    c = 8'h66;
        3'd1:    c = 8'h61;
        3'd2:    c = 8'h6C;
        3'd3:    c = 8'h73;
        3'd4:    c = 8'h65;
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

endpackage

FILE: src/itr_bcd.sv
module itr_bcd (
  input  logic                     clk_i,
  input  logic                     clear_i,
  input  logic                     shift_i,
  input  logic                     bit_i,
  output logic [itr_pkg::BCD_W-1:0] bcd_o
);
  import itr_pkg::*;

  logic [BCD_W-1:0] bcd_q, bcd_d, adj;

  // add 3 to every digit of five or more, then shift the next bit in
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
    bcd_d = bcd_q;
    if (clear_i) begin
      bcd_d = '0;
    end else if (shift_i) begin
      bcd_d = {adj[BCD_W-2:0], bit_i};
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
  end

  assign bcd_o = bcd_q;

endmodule

FILE: src/itr_packer.sv
module itr_packer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  itr_pkg::char_t             chr_i,
  output logic                       chr_ready_o,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [itr_pkg::OUT_W-1:0]  m_tdata,   // text_chars[63:0], char_count[67:64]
  output logic                       m_tlast
);
  import itr_pkg::*;

  logic [VAL_W-1:0] asm_q, asm_d;
  logic [IDX_W-1:0] idx_q;
  logic [VAL_W-1:0] text_q;
  logic [CNT_W-1:0] count_q;
  logic             valid_q, last_q;
  logic             take, flush;

  // take a character only when a finished word has room to go
  assign chr_ready_o = !valid_q || m_tready;
  assign take        = chr_i.valid && chr_ready_o;
  assign flush       = chr_i.last || (idx_q == IDX_W'(CHARS_PER_RESULT - 1));

  always_comb begin
    for (int b = 0; b < VAL_W / 8; b++) begin
      if (b >= CHARS_PER_RESULT) begin
        asm_d[8*b +: 8] = 8'h00;
      end else if (IDX_W'(b) < idx_q) begin
        asm_d[8*b +: 8] = asm_q[8*b +: 8];
      end else if (IDX_W'(b) == idx_q) begin
        asm_d[8*b +: 8] = chr_i.ch;
      end else begin
        asm_d[8*b +: 8] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (take && flush) begin
        valid_q <= 1'b1;
        idx_q   <= '0;
      end else begin
        if (take) begin
          idx_q <= idx_q + 1'b1;
        end
        if (m_tready) begin
          valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      asm_q <= asm_d;
      if (flush) begin
        text_q  <= asm_d;
        count_q <= CNT_W'(idx_q) + 1'b1;
        last_q  <= chr_i.last;
      end
    end
  end

  assign m_tvalid = valid_q;
  assign m_tdata  = {{(OUT_W - VAL_W - CNT_W){1'b0}}, count_q, text_q};
  assign m_tlast  = last_q;

endmodule

FILE: src/integer_to_text_radix_formatter.sv
// Formats one integer per input word as ASCII text, most significant character
// first, eight characters to an output word with the first character in the low
// byte; the final word of a string carries tlast. Formats are binary with 0b,
// decimal, uppercase hex with 0x, a 16-digit pointer and true/false; undefined
// selectors are dropped without output. A word is accepted in idle, then decimal
// runs one double-dabble step per operand bit (32 or 64) and a load of the BCD
// digits, then binary, decimal and hex skip the suppressed leading zero digits
// and leave the scan, and the characters follow, since the digit shift register
// moves one digit and the packer takes one character each cycle while the output
// is not stalled. Downstream stalls hold the character output.
module integer_to_text_radix_formatter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [itr_pkg::IN_W-1:0]  s_tdata,   // cmd[2:0], value[66:3], is_signed[67], is_wide[68]
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [itr_pkg::OUT_W-1:0] m_tdata,   // text_chars[63:0], char_count[67:64]
  output logic                      m_tlast
);
  import itr_pkg::*;

  state_e state_q, state_d;

  logic [2:0]        cmd_q;
  logic              neg_q, bool_q;
  logic [VAL_W-1:0]  mag_q;
  logic [DIG_W-1:0]  dig_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [2:0]        bidx_q;

  logic [2:0]        in_cmd;
  logic [VAL_W-1:0]  in_value, in_v, in_negv, in_mag, in_align;
  logic              in_sgn, in_wide, in_neg;
  logic [DCNT_W-1:0] in_cnt;

  logic [3:0]        dig_top;
  logic              bool_last;
  logic              accept;
  logic [BCD_W-1:0]  bcd;
  char_t             chr;
  logic              chr_ready;
  logic              bcd_clear, bcd_shift;

  assign in_cmd   = s_tdata[2:0];
  assign in_value = s_tdata[66:3];
  assign in_sgn   = s_tdata[67];
  assign in_wide  = s_tdata[68];
  assign accept   = s_tvalid && s_tready;

  // magnitude, left-aligned so the top operand bit sits at bit 63
  always_comb begin
    in_v     = in_wide ? in_value : {32'b0, in_value[31:0]};
    in_neg   = in_sgn && (in_wide ? in_value[63] : in_value[31]) &&
               (in_cmd inside {CMD_BIN, CMD_DEC, CMD_HEX});
    in_negv  = ~in_v + 1'b1;
    in_mag   = in_neg ? (in_wide ? in_negv : {32'b0, in_negv[31:0]}) : in_v;
    in_align = in_wide ? in_mag : {in_mag[31:0], 32'b0};
    in_cnt   = '0;
    case (in_cmd)
      CMD_BIN: in_cnt = in_wide ? DCNT_W'(64) : DCNT_W'(32);
      CMD_DEC: in_cnt = in_wide ? DCNT_W'(64) : DCNT_W'(32);
      CMD_HEX: in_cnt = in_wide ? DCNT_W'(16) : DCNT_W'(8);
      CMD_PTR: begin
        in_cnt   = DCNT_W'(16);
        in_align = in_value;
      end
      default: in_cnt = '0;
    endcase
  end

  assign dig_top   = (cmd_q == CMD_BIN) ? {3'b000, dig_q[DIG_W-1]} : dig_q[DIG_W-1 -: 4];
  assign bool_last = bool_q ? (bidx_q == 3'd3) : (bidx_q == 3'd4);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid) begin
          case (in_cmd)
            CMD_BIN:  state_d = ST_SKIP;
            CMD_HEX:  state_d = ST_SKIP;
            CMD_DEC:  state_d = ST_CONV;
            CMD_PTR:  state_d = ST_PFX0;
            CMD_BOOL: state_d = ST_BOOL;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_CONV: begin
        if (cnt_q == DCNT_W'(1)) begin
          state_d = ST_DLOAD;
        end
      end
      ST_DLOAD: state_d = ST_SKIP;
      ST_SKIP: begin
        if (!(dig_top == 4'd0 && cnt_q > DCNT_W'(1))) begin
          if (neg_q) begin
            state_d = ST_SIGN;
          end else if (cmd_q == CMD_DEC) begin
            state_d = ST_DIGS;
          end else begin
            state_d = ST_PFX0;
          end
        end
      end
      ST_SIGN: begin
        if (chr_ready) begin
          state_d = (cmd_q == CMD_DEC) ? ST_DIGS : ST_PFX0;
        end
      end
      ST_PFX0: begin
        if (chr_ready) begin
          state_d = ST_PFX1;
        end
      end
      ST_PFX1: begin
        if (chr_ready) begin
          state_d = ST_DIGS;
        end
      end
      ST_DIGS: begin
        if (chr_ready && cnt_q == DCNT_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_BOOL: begin
        if (chr_ready && bool_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    bcd_clear = 1'b0;
    bcd_shift = 1'b0;
    chr       = '0;
    case (state_q)
      ST_IDLE: begin
        s_tready  = 1'b1;
        bcd_clear = 1'b1;
      end
      ST_CONV: bcd_shift = 1'b1;
      ST_SIGN: begin
        chr.valid = 1'b1;
        chr.ch    = CH_MINUS;
      end
      ST_PFX0: begin
        chr.valid = 1'b1;
        chr.ch    = CH_ZERO;
      end
      ST_PFX1: begin
        chr.valid = 1'b1;
        chr.ch    = (cmd_q == CMD_BIN) ? CH_B : CH_X;
      end
      ST_DIGS: begin
        chr.valid = 1'b1;
        chr.last  = (cnt_q == DCNT_W'(1));
        chr.ch    = digit_char(dig_top);
      end
      ST_BOOL: begin
        chr.valid = 1'b1;
        chr.last  = bool_last;
        chr.ch    = bool_char(bool_q, bidx_q);
      end
      default: chr = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      bidx_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cnt_q  <= in_cnt;
            bidx_q <= '0;
          end
        end
        ST_CONV: cnt_q <= cnt_q - 1'b1;
        ST_DLOAD: cnt_q <= DCNT_W'(BCD_DIGITS);
        ST_SKIP: begin
          if (dig_top == 4'd0 && cnt_q > DCNT_W'(1)) begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_DIGS: begin
          if (chr_ready) begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_BOOL: begin
          if (chr_ready) begin
            bidx_q <= bidx_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_q  <= in_cmd;
          neg_q  <= in_neg;
          bool_q <= in_value[0];
          mag_q  <= in_align;
          dig_q  <= {in_align, {(DIG_W - VAL_W){1'b0}}};
        end
      end
      ST_CONV: mag_q <= {mag_q[VAL_W-2:0], 1'b0};
      ST_DLOAD: dig_q <= bcd;
      ST_SKIP: begin
        if (dig_top == 4'd0 && cnt_q > DCNT_W'(1)) begin
          dig_q <= (cmd_q == CMD_BIN) ? {dig_q[DIG_W-2:0], 1'b0} : {dig_q[DIG_W-5:0], 4'h0};
        end
      end
      ST_DIGS: begin
        if (chr_ready) begin
          dig_q <= (cmd_q == CMD_BIN) ? {dig_q[DIG_W-2:0], 1'b0} : {dig_q[DIG_W-5:0], 4'h0};
        end
      end
      default: ;
    endcase
  end

  itr_bcd u_bcd (
    .clk_i   (clk_i),
    .clear_i (bcd_clear),
    .shift_i (bcd_shift),
    .bit_i   (mag_q[VAL_W-1]),
    .bcd_o   (bcd)
  );

  itr_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .chr_i       (chr),
    .chr_ready_o (chr_ready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule

FILE: src/itr_checker.sv
module itr_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [itr_pkg::IN_W-1:0]  s_tdata,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [itr_pkg::OUT_W-1:0] m_tdata,
  input  logic                      m_tlast
);
  import itr_pkg::*;

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_full_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tlast |-> m_tdata[VAL_W +: CNT_W] == CNT_W'(CHARS_PER_RESULT))
    else $error("word before the last one is not full");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> m_tdata[VAL_W +: CNT_W] != '0 &&
                 m_tdata[VAL_W +: CNT_W] <= CNT_W'(CHARS_PER_RESULT))
    else $error("character count out of range");

  // drop an undefined selector and stay ready
  a_drop_bad_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready && (s_tdata[2:0] > CMD_BOOL) |=> s_tready)
    else $error("undefined selector was not dropped");

endmodule

bind integer_to_text_radix_formatter itr_checker u_itr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

FILE: test/text_format_checker.sv
module text_format_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [itr_pkg::IN_W-1:0]  s_tdata,   // cmd[2:0], value[66:3], is_signed[67], is_wide[68]
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [itr_pkg::OUT_W-1:0] m_tdata,   // text_chars[63:0], char_count[67:64]
  input  logic                      m_tlast,
  output int                        mismatches_o,
  output int                        words_checked_o,
  output int                        words_pending_o
);
  import itr_pkg::*;

  localparam logic [127:0] HEX_DIGITS = "0123456789ABCDEF";
  localparam logic [31:0]  TXT_TRUE   = "true";
  localparam logic [39:0]  TXT_FALSE  = "false";
  localparam int           TEXT_MAX   = 72;

  typedef struct packed {
    logic [63:0] chars;
    logic [3:0]  count;
    logic        last;
  } text_word_t;

  text_word_t expected_words[$];
  int         err_count     = 0;
  int         checked_count = 0;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    return HEX_DIGITS[8 * (15 - d) +: 8];
  endfunction

  // Build the text of one input word and queue it as packed output words.
  function automatic void predict_text(input logic [2:0] cmd, input logic [63:0] value,
                                       input logic sgn, input logic wide);
    logic [7:0]  txt [TEXT_MAX];
    logic [7:0]  rev [64];
    int          n;
    int          r;
    int          pos;
    int          cnt;
    logic [63:0] mask;
    logic [63:0] v;
    logic [63:0] mag;
    logic [63:0] radix;
    logic [63:0] rem;
    logic        neg;
    text_word_t  w;
    n = 0;
    r = 0;
    case (cmd)
      CMD_BIN, CMD_DEC, CMD_HEX: begin
        mask  = wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
        v     = value & mask;
        neg   = sgn && (wide ? v[63] : v[31]);
        mag   = neg ? ((~v + 64'd1) & mask) : v;
        radix = (cmd == CMD_BIN) ? 64'd2 : (cmd == CMD_DEC) ? 64'd10 : 64'd16;
        if (neg) begin
          txt[n] = "-";
          n++;
        end
        if (cmd != CMD_DEC) begin
          txt[n]     = "0";
          txt[n + 1] = (cmd == CMD_BIN) ? "b" : "x";
          n += 2;
        end
        // digits come out least significant first
        do begin
          rem    = mag % radix;
          rev[r] = hex_char(rem[3:0]);
          mag    = mag / radix;
          r++;
        end while (mag != 0);
        while (r > 0) begin
          r--;
          txt[n] = rev[r];
          n++;
        end
      end
      CMD_PTR: begin
        txt[0] = "0";
        txt[1] = "x";
        n = 2;
        for (int i = 0; i < 16; i++) begin
          txt[n] = hex_char(value[(60 - 4 * i) +: 4]);
          n++;
        end
      end
      CMD_BOOL: begin
        if (value[0]) begin
          for (int i = 0; i < 4; i++) txt[i] = TXT_TRUE[8 * (3 - i) +: 8];
          n = 4;
        end else begin
          for (int i = 0; i < 5; i++) txt[i] = TXT_FALSE[8 * (4 - i) +: 8];
          n = 5;
        end
      end
      default: begin
        // undefined selector: dropped with no output
        n = 0;
      end
    endcase
    pos = 0;
    while (pos < n) begin
      cnt = n - pos;
      if (cnt > CHARS_PER_RESULT) cnt = CHARS_PER_RESULT;
      w.chars = '0;
      for (int i = 0; i < cnt; i++) w.chars[8 * i +: 8] = txt[pos + i];
      pos += cnt;
      w.count = cnt[3:0];
      w.last  = (pos >= n);
      expected_words.push_back(w);
    end
  endfunction

  always @(posedge clk_i) begin
    text_word_t exp_w;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          if (err_count < 10)
            $display("%0t: unexpected word chars=%h count=%0d last=%b", $realtime,
                     m_tdata[63:0], m_tdata[67:64], m_tlast);
          err_count++;
        end else begin
          exp_w = expected_words.pop_front();
          checked_count++;
          if (m_tdata[63:0] !== exp_w.chars || m_tdata[67:64] !== exp_w.count ||
              m_tlast !== exp_w.last) begin
            if (err_count < 10)
              $display("%0t: mismatch exp chars=%h cnt=%0d last=%b got chars=%h cnt=%0d last=%b",
                       $realtime, exp_w.chars, exp_w.count, exp_w.last,
                       m_tdata[63:0], m_tdata[67:64], m_tlast);
            err_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        predict_text(s_tdata[2:0], s_tdata[66:3], s_tdata[67], s_tdata[68]);
    end
    mismatches_o    <= err_count;
    words_checked_o <= checked_count;
    words_pending_o <= expected_words.size();
  end

endmodule

FILE: test/integer_to_text_radix_formatter_tb.sv
module integer_to_text_radix_formatter_tb;
  import itr_pkg::*;

  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         TAIL_CYCLES  = 200;
  localparam int         RANDOM_ITEMS = 21;    // per idling phase
  localparam logic [2:0] CMD_UNDEF_LO = 3'd5;
  localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

  logic             clk_i;
  logic             rst_ni   = 1'b0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;

  int mismatches;
  int words_checked;
  int words_pending;
  int idle_pct      = 0;
  int stall_pct     = 0;
  int items_sent    = 0;
  int cycles        = 0;

  integer_to_text_radix_formatter dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  text_format_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast),
    .mismatches_o    (mismatches),
    .words_checked_o (words_checked),
    .words_pending_o (words_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_tready <= rst_ni && ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, words_pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Hold the word until the block takes it; drop tvalid only across a gap.
  task automatic send_word(input logic [2:0] cmd, input logic [63:0] value,
                           input logic sgn, input logic wide);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, wide, sgn, value, cmd};
    do @(posedge clk_i); while (!s_tready);
    if (cmd <= CMD_BOOL) items_sent++;
  endtask

  task automatic run_phase(input int idle, input int stall);
    int          kind;
    logic [2:0]  cmd;
    logic [63:0] value;
    int          n;
    idle_pct  = idle;
    stall_pct = stall;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 19);
      cmd  = (kind == 19) ? 3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI)) : 3'(kind % 5);
      case ($urandom_range(0, 3))
        0: value = {$urandom, $urandom};
        1: value = 64'($urandom_range(0, 20));
        2: begin
          case ($urandom_range(0, 5))
            0: value = 64'h0;
            1: value = 64'hFFFF_FFFF_FFFF_FFFF;
            2: value = 64'h8000_0000_0000_0000;
            3: value = 64'h7FFF_FFFF_FFFF_FFFF;
            4: value = {$urandom, 32'h8000_0000};
            default: value = {$urandom, 32'h7FFF_FFFF};
          endcase
        end
        default: value = {32'hFFFF_FFFF, $urandom | 32'h8000_0000};
      endcase
      send_word(cmd, value, 1'($urandom), 1'($urandom));
      if (cmd <= CMD_BOOL) n++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes of every format and the special cases
    send_word(CMD_BIN,  64'h8000_0000_0000_0000, 1'b1, 1'b1);  // longest text
    send_word(CMD_BIN,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
    send_word(CMD_BIN,  64'h0,                   1'b0, 1'b0);
    send_word(CMD_BIN,  64'hA5A5_A5A5_8000_0000, 1'b1, 1'b0);
    send_word(CMD_BIN,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    send_word(CMD_DEC,  64'h8000_0000_0000_0000, 1'b1, 1'b1);
    send_word(CMD_DEC,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
    send_word(CMD_DEC,  64'h0,                   1'b1, 1'b1);
    send_word(CMD_DEC,  64'h0000_0000_7FFF_FFFF, 1'b1, 1'b0);
    send_word(CMD_DEC,  64'hDEAD_BEEF_8000_0000, 1'b1, 1'b0);
    send_word(CMD_DEC,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
    send_word(CMD_HEX,  64'h0,                   1'b0, 1'b0);
    send_word(CMD_HEX,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
    send_word(CMD_HEX,  64'h8000_0000_0000_0000, 1'b1, 1'b1);
    send_word(CMD_HEX,  64'h0123_4567_89AB_CDEF, 1'b0, 1'b1);
    send_word(CMD_PTR,  64'h0,                   1'b0, 1'b0);
    send_word(CMD_PTR,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
    send_word(CMD_PTR,  64'hFEDC_BA98_7654_3210, 1'b1, 1'b0);
    send_word(CMD_BOOL, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
    send_word(CMD_BOOL, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0);
    send_word(CMD_BOOL, 64'h0,                   1'b0, 1'b1);
    send_word(CMD_UNDEF_LO,  {$urandom, $urandom}, 1'b1, 1'b1);
    send_word(3'd6,          {$urandom, $urandom}, 1'b0, 1'b0);
    send_word(CMD_UNDEF_HI,  {$urandom, $urandom}, 1'b1, 1'b0);
    send_word(CMD_DEC,  64'd10,                  1'b0, 1'b0);

    run_phase(0, 0);
    run_phase(80, 0);
    run_phase(0, 80);
    run_phase(20, 20);
    s_tvalid <= 1'b0;

    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("sent %0d formatted integers over four idling phases, checked %0d output words",
             items_sent, words_checked);
    $display("covered binary, decimal, hex, pointer, boolean and undefined selectors");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
